### sv/fgm_pkg.sv
// ----------------------------------------------------------------------------
// fgm_pkg
// Shared types and constants for the face geometry pipeline.
// ----------------------------------------------------------------------------
package fgm_pkg;

  localparam int UNIT_FRAC = 30;           // fraction bits of unit components
  localparam int N_NORM    = 5;            // shift cells: 16, 8, 4, 2, 1
  localparam int N_ROOT    = 33;           // root bits, one cell each
  localparam int N_QUO     = 31;           // quotient bits, one cell each
  localparam int RAD_W     = 2 * N_ROOT;   // radicand width
  localparam int REM_W     = 36;           // root remainder width
  localparam int ROOT_W    = 34;           // rounded root width
  localparam int DREM_W    = 34;           // divider remainder width

  // Lane order for roots: face raw, face normalized, centre raw, centre normalized.
  // Lane order for quotients: face x, face y, centre x, centre y.
  typedef struct packed {
    logic signed [31:0]            mid_x;
    logic signed [31:0]            mid_y;
    logic [3:0]                    neg;
    logic                          zf;
    logic                          zd;
    logic [1:0][1:0][31:0]         mag;
    logic [1:0][1:0][31:0]         nmag;
    logic [3:0][1:0][63:0]         sq;
    logic [3:0][RAD_W-1:0]         rad;
    logic [3:0][REM_W-1:0]         rem;
    logic [3:0][ROOT_W-1:0]        root;
    logic [31:0]                   flen;
    logic [31:0]                   cdist;
    logic [1:0][ROOT_W-1:0]        dlen;
    logic [3:0][N_QUO-1:0]         dnum;
    logic [3:0][DREM_W-1:0]        drem;
    logic [3:0][N_QUO-1:0]         dq;
    logic signed [31:0]            nx;
    logic signed [31:0]            ny;
    logic signed [31:0]            ex;
    logic signed [31:0]            ey;
    logic signed [63:0]            dot0;
    logic signed [63:0]            dot1;
  } fgm_word_t;

endpackage

### sv/face_geometry_metrics.sv
// ----------------------------------------------------------------------------
// face_geometry_metrics
// Midpoint, length, unit normal, centre distance and unit direction of one
// mesh face per word, as a row of pipeline cells.
// ----------------------------------------------------------------------------
// From the input accept edge to result valid a word passes 76 registers.
// Throughput: one face word per cycle unless stalled; each cell advances when it
//   is empty or its neighbor takes its word, so bubbles close up under stall.
// Latency is set by the single-bit root and quotient cells (33 and 31).
// Reset clears every valid bit; payload registers hold until overwritten.
module face_geometry_metrics import fgm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               face_valid,
  output logic               face_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] owner_cx,
  input  logic signed [31:0] owner_cy,
  input  logic signed [31:0] neighbour_cx,
  input  logic signed [31:0] neighbour_cy,
  input  logic               on_boundary,
  output logic               metric_valid,
  input  logic               metric_stall,
  output logic signed [31:0] mid_x,
  output logic signed [31:0] mid_y,
  output logic [31:0]        face_length,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic [31:0]        centre_distance,
  output logic signed [31:0] dir_x,
  output logic signed [31:0] dir_y,
  output logic               degenerate
);

  // --------------------------------------------------------------------------
  // Front stage: midpoint and edge vector, hold the centroids for next stage.
  // --------------------------------------------------------------------------
  logic               a_valid, a_ready;
  logic signed [31:0] a_mid_x, a_mid_y;
  logic signed [32:0] a_fd_x, a_fd_y;
  logic signed [31:0] a_ox, a_oy, a_nb_x, a_nb_y;
  logic               a_bnd;
  logic               b_ready;

  logic signed [32:0] sum_x, sum_y;

  assign sum_x = 33'(start_x) + 33'(end_x);
  assign sum_y = 33'(start_y) + 33'(end_y);

  assign a_ready    = !a_valid || b_ready;
  assign face_stall = !a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= face_valid;
    end
  end

  // floor of the half sum is the arithmetic shift of the 33-bit sum
  always_ff @(posedge clk) begin
    if (a_ready && face_valid) begin
      a_mid_x <= 32'(sum_x >>> 1);
      a_mid_y <= 32'(sum_y >>> 1);
      a_fd_x  <= 33'(end_x) - 33'(start_x);
      a_fd_y  <= 33'(end_y) - 33'(start_y);
      a_ox    <= owner_cx;
      a_oy    <= owner_cy;
      a_nb_x  <= neighbour_cx;
      a_nb_y  <= neighbour_cy;
      a_bnd   <= on_boundary;
    end
  end

  // --------------------------------------------------------------------------
  // Centre stage: boundary faces use the midpoint in place of the neighbour.
  // Split both vectors into sign and magnitude.
  // --------------------------------------------------------------------------
  fgm_word_t          b_next;
  logic signed [32:0] cd_x, cd_y;

  assign cd_x = (a_bnd ? 33'(a_mid_x) : 33'(a_nb_x)) - 33'(a_ox);
  assign cd_y = (a_bnd ? 33'(a_mid_y) : 33'(a_nb_y)) - 33'(a_oy);

  always_comb begin
    b_next            = '0;
    b_next.mid_x      = a_mid_x;
    b_next.mid_y      = a_mid_y;
    b_next.neg        = {cd_y[32], cd_x[32], a_fd_y[32], a_fd_x[32]};
    b_next.mag[0][0]  = 32'(a_fd_x[32] ? -a_fd_x : a_fd_x);
    b_next.mag[0][1]  = 32'(a_fd_y[32] ? -a_fd_y : a_fd_y);
    b_next.mag[1][0]  = 32'(cd_x[32] ? -cd_x : cd_x);
    b_next.mag[1][1]  = 32'(cd_y[32] ? -cd_y : cd_y);
    b_next.nmag       = b_next.mag;
    b_next.zf         = (a_fd_x == 33'sd0) && (a_fd_y == 33'sd0);
    b_next.zd         = (cd_x == 33'sd0) && (cd_y == 33'sd0);
  end

  fgm_word_t nrm_word  [0:N_NORM];
  logic      nrm_valid [0:N_NORM];
  logic      nrm_ready [0:N_NORM];

  fgm_stage u_centre (
    .clk(clk), .rst(rst), .valid_in(a_valid), .word_in(b_next), .ready_in(nrm_ready[0]),
    .ready(b_ready), .valid(nrm_valid[0]), .word(nrm_word[0])
  );

  // --------------------------------------------------------------------------
  // Normalize: shift cells by 16, 8, 4, 2, 1 bring the larger magnitude to
  // the top bit.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N_NORM; i++) begin : g_norm
    fgm_norm_cell u_cell (
      .clk(clk), .rst(rst), .shift(5'(16 >> i)),
      .valid_in(nrm_valid[i]), .word_in(nrm_word[i]), .ready_in(nrm_ready[i+1]),
      .ready(nrm_ready[i]), .valid(nrm_valid[i+1]), .word(nrm_word[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Squares, then sums of squares, which seed the root cells.
  // --------------------------------------------------------------------------
  fgm_word_t sq_next, sq_word, sum_next;
  logic      sq_valid, sum_ready;

  always_comb begin
    sq_next = nrm_word[N_NORM];
    for (int v = 0; v < 2; v++) begin
      for (int c = 0; c < 2; c++) begin
        sq_next.sq[2*v][c]   = 64'(nrm_word[N_NORM].mag[v][c])
                             * 64'(nrm_word[N_NORM].mag[v][c]);
        sq_next.sq[2*v+1][c] = 64'(nrm_word[N_NORM].nmag[v][c])
                             * 64'(nrm_word[N_NORM].nmag[v][c]);
      end
    end
  end

  fgm_stage u_square (
    .clk(clk), .rst(rst), .valid_in(nrm_valid[N_NORM]), .word_in(sq_next),
    .ready_in(sum_ready), .ready(nrm_ready[N_NORM]), .valid(sq_valid), .word(sq_word)
  );

  fgm_word_t rt_word  [0:N_ROOT];
  logic      rt_valid [0:N_ROOT];
  logic      rt_ready [0:N_ROOT];

  always_comb begin
    sum_next = sq_word;
    for (int l = 0; l < 4; l++) begin
      sum_next.rad[l]  = RAD_W'(sq_word.sq[l][0]) + RAD_W'(sq_word.sq[l][1]);
      sum_next.rem[l]  = '0;
      sum_next.root[l] = '0;
    end
  end

  fgm_stage u_sum (
    .clk(clk), .rst(rst), .valid_in(sq_valid), .word_in(sum_next),
    .ready_in(rt_ready[0]), .ready(sum_ready), .valid(rt_valid[0]), .word(rt_word[0])
  );

  // --------------------------------------------------------------------------
  // Root cells: one root bit per cell, four lanes side by side.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N_ROOT; i++) begin : g_root
    fgm_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .valid_in(rt_valid[i]), .word_in(rt_word[i]), .ready_in(rt_ready[i+1]),
      .ready(rt_ready[i]), .valid(rt_valid[i+1]), .word(rt_word[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Round the roots to nearest (tie up), saturate the lengths and seed the
  // divider with |c| * 2^30 + L/2.
  // --------------------------------------------------------------------------
  fgm_word_t rnd_next;

  fgm_word_t dv_word  [0:N_QUO];
  logic      dv_valid [0:N_QUO];
  logic      dv_ready [0:N_QUO];

  always_comb begin
    logic [3:0][ROOT_W-1:0]   rl;
    logic [ROOT_W-1:0]        dvs;
    logic [N_QUO+31:0]        num;
    rnd_next = rt_word[N_ROOT];
    for (int l = 0; l < 4; l++) begin
      rl[l] = rt_word[N_ROOT].root[l]
            + ROOT_W'(rt_word[N_ROOT].rem[l] > REM_W'(rt_word[N_ROOT].root[l]));
    end
    rnd_next.flen    = (rl[0][ROOT_W-1:32] != '0) ? '1 : rl[0][31:0];
    rnd_next.cdist   = (rl[2][ROOT_W-1:32] != '0) ? '1 : rl[2][31:0];
    rnd_next.dlen[0] = rl[1];
    rnd_next.dlen[1] = rl[3];
    for (int l = 0; l < 4; l++) begin
      dvs = (l < 2) ? rl[1] : rl[3];
      num = {1'b0, rt_word[N_ROOT].nmag[l/2][l%2], UNIT_FRAC'(0)}
          + (N_QUO+32)'(dvs >> 1);
      rnd_next.drem[l] = DREM_W'(num[N_QUO+31:N_QUO]);
      rnd_next.dnum[l] = num[N_QUO-1:0];
      rnd_next.dq[l]   = '0;
    end
  end

  fgm_stage u_round (
    .clk(clk), .rst(rst), .valid_in(rt_valid[N_ROOT]), .word_in(rnd_next),
    .ready_in(dv_ready[0]), .ready(rt_ready[N_ROOT]), .valid(dv_valid[0]),
    .word(dv_word[0])
  );

  // --------------------------------------------------------------------------
  // Divider cells: one quotient bit per cell, four lanes side by side.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < N_QUO; i++) begin : g_div
    fgm_div_cell u_cell (
      .clk(clk), .rst(rst),
      .valid_in(dv_valid[i]), .word_in(dv_word[i]), .ready_in(dv_ready[i+1]),
      .ready(dv_ready[i]), .valid(dv_valid[i+1]), .word(dv_word[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Apply signs, zero the unit vectors of degenerate vectors, turn the edge
  // a quarter turn left and form the two dot-product terms.
  // --------------------------------------------------------------------------
  fgm_word_t dot_next, dot_word, out_next, out_word;
  logic      dot_valid, out_ready, out_valid;

  always_comb begin
    logic signed [3:0][31:0] u;
    dot_next = dv_word[N_QUO];
    for (int l = 0; l < 4; l++) begin
      u[l] = dv_word[N_QUO].neg[l] ? -$signed({1'b0, dv_word[N_QUO].dq[l]})
                                   : $signed({1'b0, dv_word[N_QUO].dq[l]});
    end
    if (dv_word[N_QUO].zf) begin
      u[0] = '0;
      u[1] = '0;
    end
    if (dv_word[N_QUO].zd) begin
      u[2] = '0;
      u[3] = '0;
    end
    dot_next.nx   = -$signed(u[1]);
    dot_next.ny   = $signed(u[0]);
    dot_next.ex   = $signed(u[2]);
    dot_next.ey   = $signed(u[3]);
    dot_next.dot0 = $signed(u[2]) * (-$signed(u[1]));
    dot_next.dot1 = $signed(u[3]) * $signed(u[0]);
  end

  fgm_stage u_dot (
    .clk(clk), .rst(rst), .valid_in(dv_valid[N_QUO]), .word_in(dot_next),
    .ready_in(out_ready), .ready(dv_ready[N_QUO]), .valid(dot_valid), .word(dot_word)
  );

  // --------------------------------------------------------------------------
  // Output register: flip the normal when it points against the direction.
  // --------------------------------------------------------------------------
  logic signed [64:0] dot_sum;

  assign dot_sum = 65'(dot_word.dot0) + 65'(dot_word.dot1);

  always_comb begin
    out_next = dot_word;
    if (dot_sum < 65'sd0) begin
      out_next.nx = -dot_word.nx;
      out_next.ny = -dot_word.ny;
    end
  end

  fgm_stage u_out (
    .clk(clk), .rst(rst), .valid_in(dot_valid), .word_in(out_next),
    .ready_in(!metric_stall), .ready(out_ready), .valid(out_valid), .word(out_word)
  );

  assign metric_valid    = out_valid;
  assign mid_x           = out_word.mid_x;
  assign mid_y           = out_word.mid_y;
  assign face_length     = out_word.flen;
  assign normal_x        = out_word.nx;
  assign normal_y        = out_word.ny;
  assign centre_distance = out_word.cdist;
  assign dir_x           = out_word.ex;
  assign dir_y           = out_word.ey;
  assign degenerate      = out_word.zf || out_word.zd;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_nondegen_len: assert property (@(posedge clk) disable iff (rst)
    (metric_valid && !degenerate) |-> (face_length != 32'd0 && centre_distance != 32'd0))
    else $error("nonzero vectors gave a zero length");

  a_zero_face: assert property (@(posedge clk) disable iff (rst)
    (metric_valid && out_word.zf) |-> (normal_x == 32'sd0 && normal_y == 32'sd0
                                       && face_length == 32'd0))
    else $error("degenerate face left a nonzero normal");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (metric_valid && out_word.zd) |-> (dir_x == 32'sd0 && dir_y == 32'sd0
                                       && centre_distance == 32'd0))
    else $error("degenerate centre vector left a nonzero direction");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    metric_valid |-> (dir_x <= 32'sd1073741824 && dir_x >= -32'sd1073741824
                      && normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824))
    else $error("unit component out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (dot_valid && !metric_valid) |=> metric_valid)
    else $error("output register failed to take a ready word");

endmodule

### sv/fgm_stage.sv
// ----------------------------------------------------------------------------
// fgm_stage
// One pipeline register with valid and bubble-collapsing ready.
// ----------------------------------------------------------------------------
module fgm_stage import fgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid_in,
  input  fgm_word_t word_in,
  input  logic      ready_in,
  output logic      ready,
  output logic      valid,
  output fgm_word_t word
);

  // advance when empty or when downstream takes the held word
  assign ready = !valid || ready_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_in) begin
      word <= word_in;
    end
  end

endmodule

### sv/fgm_norm_cell.sv
// ----------------------------------------------------------------------------
// fgm_norm_cell
// One step of the normalizing shift: shift each vector left by a fixed amount
// when its own larger magnitude leaves room for it.
// ----------------------------------------------------------------------------
module fgm_norm_cell import fgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic [4:0] shift,
  input  logic      valid_in,
  input  fgm_word_t word_in,
  input  logic      ready_in,
  output logic      ready,
  output logic      valid,
  output fgm_word_t word
);

  fgm_word_t nxt;

  always_comb begin
    logic [31:0] top;
    nxt = word_in;
    for (int v = 0; v < 2; v++) begin
      top = (word_in.nmag[v][0] > word_in.nmag[v][1]) ? word_in.nmag[v][0]
                                                      : word_in.nmag[v][1];
      if ((top >> (6'd32 - {1'b0, shift})) == 32'd0) begin
        nxt.nmag[v][0] = word_in.nmag[v][0] << shift;
        nxt.nmag[v][1] = word_in.nmag[v][1] << shift;
      end
    end
  end

  fgm_stage u_reg (
    .clk(clk), .rst(rst), .valid_in(valid_in), .word_in(nxt), .ready_in(ready_in),
    .ready(ready), .valid(valid), .word(word)
  );

endmodule

### sv/fgm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fgm_sqrt_cell
// One root bit for each of four lanes, restoring digit-by-digit square root.
// ----------------------------------------------------------------------------
module fgm_sqrt_cell import fgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid_in,
  input  fgm_word_t word_in,
  input  logic      ready_in,
  output logic      ready,
  output logic      valid,
  output fgm_word_t word
);

  fgm_word_t nxt;

  always_comb begin
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    nxt = word_in;
    for (int l = 0; l < 4; l++) begin
      // bring down the next bit pair of the radicand
      acc   = {word_in.rem[l], word_in.rad[l][RAD_W-1 -: 2]};
      trial = {2'b00, word_in.root[l], 2'b01};
      nxt.rad[l] = word_in.rad[l] << 2;
      if (acc >= trial) begin
        nxt.rem[l]  = REM_W'(acc - trial);
        nxt.root[l] = {word_in.root[l][ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem[l]  = acc[REM_W-1:0];
        nxt.root[l] = {word_in.root[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  fgm_stage u_reg (
    .clk(clk), .rst(rst), .valid_in(valid_in), .word_in(nxt), .ready_in(ready_in),
    .ready(ready), .valid(valid), .word(word)
  );

endmodule

### sv/fgm_div_cell.sv
// ----------------------------------------------------------------------------
// fgm_div_cell
// One quotient bit for each of four lanes, restoring long division.
// ----------------------------------------------------------------------------
module fgm_div_cell import fgm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      valid_in,
  input  fgm_word_t word_in,
  input  logic      ready_in,
  output logic      ready,
  output logic      valid,
  output fgm_word_t word
);

  fgm_word_t nxt;

  always_comb begin
    logic [DREM_W:0]    acc;
    logic [ROOT_W-1:0]  dvs;
    nxt = word_in;
    for (int l = 0; l < 4; l++) begin
      dvs = (l < 2) ? word_in.dlen[0] : word_in.dlen[1];
      acc = {word_in.drem[l], word_in.dnum[l][N_QUO-1]};
      nxt.dnum[l] = word_in.dnum[l] << 1;
      if (acc >= {1'b0, dvs}) begin
        nxt.drem[l] = DREM_W'(acc - {1'b0, dvs});
        nxt.dq[l]   = {word_in.dq[l][N_QUO-2:0], 1'b1};
      end else begin
        nxt.drem[l] = acc[DREM_W-1:0];
        nxt.dq[l]   = {word_in.dq[l][N_QUO-2:0], 1'b0};
      end
    end
  end

  fgm_stage u_reg (
    .clk(clk), .rst(rst), .valid_in(valid_in), .word_in(nxt), .ready_in(ready_in),
    .ready(ready), .valid(valid), .word(word)
  );

endmodule

### tb/face_metric_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_metric_checker
// Watches the face and metric channels, predicts the geometry of each
// accepted face word and compares every accepted metric word with it.
// ----------------------------------------------------------------------------
module face_metric_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               face_valid,
  input  logic               face_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] owner_cx,
  input  logic signed [31:0] owner_cy,
  input  logic signed [31:0] neighbour_cx,
  input  logic signed [31:0] neighbour_cy,
  input  logic               on_boundary,
  input  logic               metric_valid,
  input  logic               metric_stall,
  input  logic signed [31:0] mid_x,
  input  logic signed [31:0] mid_y,
  input  logic [31:0]        face_length,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic [31:0]        centre_distance,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending,
  output int                 seen
);

  typedef struct packed {
    logic [31:0] mx, my, flen, nx, ny, cdist, ex, ey;
    logic        degen;
  } metric_t;

  metric_t metric_q[$];

  // Rounded square root of a sum below 2^66.
  function automatic logic [33:0] round_root(logic [65:0] v);
    logic [33:0] r;
    logic [67:0] c2;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c2 = (68'(r | (34'd1 << b))) * (68'(r | (34'd1 << b)));
      if (c2 <= 68'(v)) r = r | (34'd1 << b);
    end
    if (68'(v) > 68'(r) * 68'(r) + 68'(r)) r = r + 1;
    return r;
  endfunction

  // Length and Q1.30 unit vector of (ax, ay); returns 1 on a zero vector.
  function automatic logic measure_vec(input logic signed [33:0] ax,
                                       input logic signed [33:0] ay,
                                       output logic [33:0] len,
                                       output logic signed [33:0] ux,
                                       output logic signed [33:0] uy);
    logic [33:0] mx, my, top, ln;
    logic [65:0] s;
    logic [63:0] qx, qy;
    mx = ax < 0 ? -ax : ax;
    my = ay < 0 ? -ay : ay;
    len = 0; ux = 0; uy = 0;
    if (mx == 0 && my == 0) return 1'b1;
    s = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
    len = round_root(s);
    top = mx > my ? mx : my;
    while (top < 34'h80000000) begin
      top = top << 1; mx = mx << 1; my = my << 1;
    end
    s = 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
    ln = round_root(s);
    qx = ((64'(mx) << 30) + 64'(ln >> 1)) / 64'(ln);
    qy = ((64'(my) << 30) + 64'(ln >> 1)) / 64'(ln);
    ux = ax < 0 ? -34'(qx) : 34'(qx);
    uy = ay < 0 ? -34'(qy) : 34'(qy);
    return 1'b0;
  endfunction

  function automatic metric_t face_geometry(
      logic signed [31:0] x1, y1, x2, y2, ox, oy, nbx, nby, logic bnd);
    metric_t m;
    logic signed [33:0] hx, hy, tx, ty, nx, ny, ex, ey, cx, cy;
    logic [33:0] fl, dl;
    logic zf, zd;
    hx = (34'(x1) + 34'(x2)) >>> 1;
    hy = (34'(y1) + 34'(y2)) >>> 1;
    zf = measure_vec(34'(x2) - 34'(x1), 34'(y2) - 34'(y1), fl, tx, ty);
    nx = -ty;
    ny = tx;
    cx = bnd ? hx : 34'(nbx);
    cy = bnd ? hy : 34'(nby);
    zd = measure_vec(cx - 34'(ox), cy - 34'(oy), dl, ex, ey);
    if (68'(ex) * 68'(nx) + 68'(ey) * 68'(ny) < 0) begin
      nx = -nx; ny = -ny;
    end
    m.mx = hx[31:0]; m.my = hy[31:0];
    m.flen = fl > 34'hFFFFFFFF ? 32'hFFFFFFFF : fl[31:0];
    m.cdist = dl > 34'hFFFFFFFF ? 32'hFFFFFFFF : dl[31:0];
    m.nx = nx[31:0]; m.ny = ny[31:0];
    m.ex = ex[31:0]; m.ey = ey[31:0];
    m.degen = zf | zd;
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: metric word %0d %s got %h want %h", $time, seen, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    seen = 0;
  end

  assign pending = metric_q.size();

  always @(posedge clk) begin
    metric_t w;
    if (!rst && face_valid && !face_stall)
      metric_q.push_back(face_geometry(start_x, start_y, end_x, end_y, owner_cx,
                                       owner_cy, neighbour_cx, neighbour_cy,
                                       on_boundary));
    if (!rst && metric_valid && !metric_stall) begin
      if (metric_q.size() == 0) begin
        $display("%0t: metric word with no face waiting", $time);
        errors++;
      end else begin
        w = metric_q.pop_front();
        if (mid_x !== w.mx) report_mismatch("mid_x", mid_x, w.mx);
        if (mid_y !== w.my) report_mismatch("mid_y", mid_y, w.my);
        if (face_length !== w.flen) report_mismatch("face_length", face_length, w.flen);
        if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
        if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
        if (centre_distance !== w.cdist)
          report_mismatch("centre_distance", centre_distance, w.cdist);
        if (dir_x !== w.ex) report_mismatch("dir_x", dir_x, w.ex);
        if (dir_y !== w.ey) report_mismatch("dir_y", dir_y, w.ey);
        if (degenerate !== w.degen)
          report_mismatch("degenerate", 32'(degenerate), 32'(w.degen));
      end
      seen++;
    end
  end

endmodule

### tb/tb_face_geometry_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_face_geometry_metrics
// Drives directed and random mesh faces through the face geometry pipeline
// with random gaps and output stalls; a checker beside it predicts and
// compares each metric word.
// ----------------------------------------------------------------------------
module tb_face_geometry_metrics;
  import fgm_pkg::*;

  localparam int LATENCY   = 75;
  localparam int N_RANDOM  = 1330;

  logic clk, rst;
  logic face_valid, face_stall, metric_valid, metric_stall;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic signed [31:0] owner_cx, owner_cy, neighbour_cx, neighbour_cy;
  logic on_boundary;
  logic signed [31:0] mid_x, mid_y, normal_x, normal_y, dir_x, dir_y;
  logic [31:0] face_length, centre_distance;
  logic degenerate;
  int errors, pending, seen;
  int n_bnd;

  face_geometry_metrics i_dut (.*);

  face_metric_checker i_check (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Generous cap: every word waiting out long gaps and long stalls.
  initial begin
    #4000000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the metric channel in random bursts, with quiet stretches.
  initial begin
    int n;
    metric_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = gap_len();
      metric_stall = 1'b1;
      repeat (n) @(negedge clk);
      metric_stall = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Coordinate mix: extremes, small values near a centre, or anything.
  function automatic logic [31:0] coord(logic [31:0] base);
    case ($urandom_range(0, 9))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return base;
      3, 4, 5: return base + $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  // Hold the word until the pipeline takes it; drop valid only if no word follows.
  task automatic send_face(logic [31:0] x1, y1, x2, y2, ox, oy, nbx, nby, logic bnd);
    face_valid = 1'b1;
    start_x = x1; start_y = y1; end_x = x2; end_y = y2;
    owner_cx = ox; owner_cy = oy; neighbour_cx = nbx; neighbour_cy = nby;
    on_boundary = bnd;
    @(posedge clk);
    while (face_stall) @(posedge clk);
    n_bnd += bnd;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      face_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] b, c[8];
    face_valid = 0; on_boundary = 0;
    start_x = 0; start_y = 0; end_x = 0; end_y = 0;
    owner_cx = 0; owner_cy = 0; neighbour_cx = 0; neighbour_cy = 0;
    n_bnd = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed faces: zero-length edge, coincident centres, saturated lengths,
    // boundary substitution, flipped normal, axis-aligned and diagonal edges.
    send_face(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0);
    send_face(0, 0, 32'h10000, 0, 5, 5, 5, 5, 0);
    send_face(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_face(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
    send_face(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0);
    send_face(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h12345678, 32'h9ABCDEF0, 1);
    send_face(0, 0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 32'h10000, 0);
    send_face(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'hFFFF0000, 0);
    send_face(0, 0, 0, 32'h10000, 32'h10000, 0, 32'hFFFF0000, 0, 0);
    send_face(0, 0, 32'h10000, 32'h10000, 1, 0, 0, 1, 0);
    send_face(1, 1, 2, 2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 0);
    send_face(3, 0, 0, 4, 0, 0, 3, 4, 0);
    send_face(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 1);
    send_face(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
              0, 0, 0, 0, 1);
    send_face(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send_face(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
              32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 0);

    // Pause until the pipeline drains.
    face_valid = 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      b = $urandom();
      foreach (c[k]) c[k] = coord(b);
      send_face(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                $urandom_range(0, 2) == 0);
      idle_gap();
    end
    face_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    $display("faces: %0d accepted, %0d boundary, %0d metric words checked",
             N_RANDOM + 16, n_bnd, seen);
    $display("covered extreme, zero-length, coincident-centre and flipped-normal faces");
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
